// ----- hw/rtl/ils_pkg.sv -----
// shared types and constants for the indexed list store
`default_nettype none

package ils_pkg;

  localparam int DEFAULT_CAPACITY   = 16;
  localparam int DEFAULT_DATA_WIDTH = 32;

  // request operation codes
  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_REMOVE = 2'd1,
    MODE_READ   = 2'd2
  } mode_t;

  // result status codes
  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_RANGE = 2'd2
  } status_t;

  // what every cell of the chain does this cycle
  typedef enum logic [1:0] {
    SHIFT_HOLD = 2'd0,
    SHIFT_UP   = 2'd1,
    SHIFT_DOWN = 2'd2
  } shift_op_t;

  // control from the sequencer to the cell chain and read port
  typedef struct packed {
    shift_op_t shift;
    logic      read_hit;
  } ils_ctrl_t;

endpackage

`default_nettype wire

// ----- hw/rtl/ils_cell.sv -----
// one storage cell of the list chain, loads from itself, a neighbor or the new value
`default_nettype none

module ils_cell
  import ils_pkg::*;
#(
  parameter int DATA_WIDTH = DEFAULT_DATA_WIDTH,
  parameter int POS_WIDTH  = 5,
  parameter int INDEX      = 0
) (
  input  wire logic                  clk,
  input  wire ils_ctrl_t             ctrl,
  input  wire logic [POS_WIDTH-1:0]  pos,
  input  wire logic [DATA_WIDTH-1:0] value,
  input  wire logic [DATA_WIDTH-1:0] lower_q,
  input  wire logic [DATA_WIDTH-1:0] upper_q,
  output logic      [DATA_WIDTH-1:0] q
);

  localparam logic [POS_WIDTH-1:0] MyIndex = POS_WIDTH'(INDEX);

  logic [DATA_WIDTH-1:0] q_next;

  // pick the source for this cell
  always_comb begin
    q_next = q;
    case (ctrl.shift)
      SHIFT_UP: begin
        if (MyIndex > pos) begin
          q_next = lower_q;
        end else if (MyIndex == pos) begin
          q_next = value;
        end
      end
      SHIFT_DOWN: begin
        if (MyIndex >= pos) begin
          q_next = upper_q;
        end
      end
      default: begin
        q_next = q;
      end
    endcase
  end

  // entry register, no reset needed
  always_ff @(posedge clk) begin
    q <= q_next;
  end

endmodule

`default_nettype wire

// ----- hw/rtl/ils_ctrl.sv -----
// request decode, entry count and result status for the list store
`default_nettype none

module ils_ctrl
  import ils_pkg::*;
#(
  parameter int CAPACITY  = DEFAULT_CAPACITY,
  parameter int POS_WIDTH = 5
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  input  wire logic [1:0]           mode,
  input  wire logic [POS_WIDTH-1:0] position,
  output ils_ctrl_t                 ctrl,
  output logic      [POS_WIDTH-1:0] eff_pos,
  output logic                      done,
  output logic      [POS_WIDTH-1:0] length,
  output logic      [1:0]           status
);

  localparam logic [POS_WIDTH-1:0] Cap = POS_WIDTH'(CAPACITY);

  logic [POS_WIDTH-1:0] count;
  logic [POS_WIDTH-1:0] count_next;
  status_t              status_next;

  // insert position clamps to the end of the list
  assign eff_pos = (position > count) ? count : position;

  // decode the request
  always_comb begin
    count_next     = count;
    status_next    = STATUS_OK;
    ctrl.shift     = SHIFT_HOLD;
    ctrl.read_hit  = 1'b0;
    if (start) begin
      unique case (mode)
        MODE_INSERT: begin
          if (count >= Cap) begin
            status_next = STATUS_FULL;
          end else begin
            ctrl.shift = SHIFT_UP;
            count_next = count + POS_WIDTH'(1);
          end
        end
        MODE_REMOVE: begin
          if (position >= count) begin
            status_next = STATUS_RANGE;
          end else begin
            ctrl.shift = SHIFT_DOWN;
            count_next = count - POS_WIDTH'(1);
          end
        end
        MODE_READ: begin
          if (position >= count) begin
            status_next = STATUS_RANGE;
          end else begin
            ctrl.read_hit = 1'b1;
          end
        end
        default: begin
          status_next = STATUS_OK;
        end
      endcase
    end
  end

  // count and result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      count <= count_next;
      done  <= start;
    end
  end

  // result fields
  always_ff @(posedge clk) begin
    if (start) begin
      length <= count_next;
      status <= status_next;
    end
  end

  // every request gives a result in the next cycle
  a_done_follows: assert property (@(posedge clk) disable iff (rst)
    start |=> done)
    else $error("request without result strobe");

  // count stays within capacity
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= Cap)
    else $error("entry count beyond capacity");

  // full status only when the store really is full
  a_full_len: assert property (@(posedge clk) disable iff (rst)
    done && status == STATUS_FULL |-> length == Cap)
    else $error("full status with free space");

  // accepted insert grows the list by one
  a_insert_grow: assert property (@(posedge clk) disable iff (rst)
    start && mode == MODE_INSERT && count < Cap |=> length == $past(count) + POS_WIDTH'(1))
    else $error("insert did not grow the list");

  // a remove that misses leaves the count alone
  a_remove_miss: assert property (@(posedge clk) disable iff (rst)
    start && mode == MODE_REMOVE && position >= count |=> count == $past(count))
    else $error("out of range remove changed the count");

endmodule

`default_nettype wire

// ----- hw/rtl/indexed_list_store.sv -----
// top level of the indexed list store: sequencer, cell chain and read port
//
// An ordered list of up to CAPACITY words held in a chain of cells, one
// entry per cell. A request (mode, position, value) is taken at a rising
// edge with start high and busy low. Insert puts value at position (clamped
// to the end) and every later cell loads from its lower neighbor; remove
// makes every cell at or above position load from its upper neighbor; read
// returns the entry at position.
// Each request gives one result in the next cycle: done is high for exactly
// one cycle with read_value, length and status. All cells shift in the same
// cycle, so a request is taken every cycle and busy stays low; throughput
// is one request per cycle.
// The read port is a CAPACITY-way select over the cell outputs.
// Status: ok, full on insert into a full list, out of range on a remove or
// read at a position not below the length (nothing changes then).
// Reset (rst, synchronous) empties the list; entry contents are not cleared.
// The receiver cannot stall: each result must be taken in its done cycle.
`default_nettype none

module indexed_list_store
  import ils_pkg::*;
#(
  parameter int CAPACITY   = DEFAULT_CAPACITY,
  parameter int DATA_WIDTH = DEFAULT_DATA_WIDTH,
  localparam int PosW      = $clog2(CAPACITY + 1),
  localparam int IdxW      = $clog2(CAPACITY)
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [1:0]            mode,
  input  wire logic [PosW-1:0]       position,
  input  wire logic [DATA_WIDTH-1:0] value,
  output logic                       done,
  output logic      [DATA_WIDTH-1:0] read_value,
  output logic      [PosW-1:0]       length,
  output logic      [1:0]            status
);

  ils_ctrl_t             ctrl;
  logic [PosW-1:0]       eff_pos;
  logic [DATA_WIDTH-1:0] cell_q [CAPACITY];

  // requests never wait
  assign busy = 1'b0;

  // request sequencer
  ils_ctrl #(
    .CAPACITY  (CAPACITY),
    .POS_WIDTH (PosW)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .mode     (mode),
    .position (position),
    .ctrl     (ctrl),
    .eff_pos  (eff_pos),
    .done     (done),
    .length   (length),
    .status   (status)
  );

  // chain of entry cells
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] lower_q;
    logic [DATA_WIDTH-1:0] upper_q;

    if (i == 0) begin : g_head
      assign lower_q = '0;
    end else begin : g_body
      assign lower_q = cell_q[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign upper_q = cell_q[i];
    end else begin : g_inner
      assign upper_q = cell_q[i+1];
    end

    ils_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .POS_WIDTH  (PosW),
      .INDEX      (i)
    ) u_cell (
      .clk     (clk),
      .ctrl    (ctrl),
      .pos     (eff_pos),
      .value   (value),
      .lower_q (lower_q),
      .upper_q (upper_q),
      .q       (cell_q[i])
    );
  end

  // read port, zero unless the read hit
  always_ff @(posedge clk) begin
    if (start) begin
      read_value <= ctrl.read_hit ? cell_q[position[IdxW-1:0]] : '0;
    end
  end

endmodule

`default_nettype wire
